>>> hw/rtl/ctms_pkg.sv
`timescale 1ns / 1ps
package ctms_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int CHAN_W  = 16;
  localparam int FLAGS_W = 5;
  localparam int MODE_W  = 4;
  localparam int ENTRY_W = CHAN_W + FLAGS_W;

  localparam logic [CHAN_W-1:0] EMPTY_CHANNEL = 16'hFFFF;

  // Capability flag bit positions
  localparam int F_24G   = 0;
  localparam int F_5G    = 1;
  localparam int F_HT20  = 2;
  localparam int F_HT40P = 3;
  localparam int F_HT40M = 4;

  // Wireless mode codes
  localparam logic [MODE_W-1:0] MODE_G        = 4'd0;
  localparam logic [MODE_W-1:0] MODE_B        = 4'd1;
  localparam logic [MODE_W-1:0] MODE_A        = 4'd2;
  localparam logic [MODE_W-1:0] MODE_NG_HT20  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_NG_HT40P = 4'd4;
  localparam logic [MODE_W-1:0] MODE_NG_HT40M = 4'd5;
  localparam logic [MODE_W-1:0] MODE_NG_HT40  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_NA_HT20  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_NA_HT40P = 4'd8;
  localparam logic [MODE_W-1:0] MODE_NA_HT40M = 4'd9;
  localparam logic [MODE_W-1:0] MODE_NA_HT40  = 4'd10;
  localparam logic [MODE_W-1:0] MODE_AC80     = 4'd11;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_FIND  = 2'd1,
    OP_LOW   = 2'd2,
    OP_HIGH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } st_t;

  // Sequencer to search datapath
  typedef struct packed {
    logic              clear;
    logic              dvld;
    logic              ent_vld;
    logic [TBL_AW-1:0] slot;
    logic              fin;
    op_t               op;
    logic [IDX_W-1:0]  item_idx;
    logic [CHAN_W-1:0] item_chan;
    logic [MODE_W-1:0] item_mode;
  } scan_ctl_t;

  // Entry eligibility under a wireless mode
  function automatic logic mode_accepts(input logic [CHAN_W-1:0]  chan,
                                        input logic [FLAGS_W-1:0] f,
                                        input logic [MODE_W-1:0]  mode);
    logic ok;
    logic ht40;
    ht40 = f[F_HT40P] | f[F_HT40M];
    case (mode)
      MODE_G, MODE_B: ok = f[F_24G];
      MODE_A:         ok = f[F_5G];
      MODE_NG_HT20:   ok = f[F_24G] & f[F_HT20];
      MODE_NG_HT40P:  ok = f[F_24G] & f[F_HT40P];
      MODE_NG_HT40M:  ok = f[F_24G] & f[F_HT40M];
      MODE_NG_HT40:   ok = f[F_24G] & ht40;
      MODE_NA_HT20:   ok = f[F_5G] & f[F_HT20];
      MODE_NA_HT40P:  ok = f[F_5G] & f[F_HT40P];
      MODE_NA_HT40M:  ok = f[F_5G] & f[F_HT40M];
      MODE_NA_HT40,
      MODE_AC80:      ok = f[F_5G] & ht40;
      default:        ok = 1'b0;
    endcase
    return ok & (chan != EMPTY_CHANNEL);
  endfunction

endpackage

>>> hw/rtl/ctms_in_if.sv
`timescale 1ns / 1ps
interface ctms_in_if;
  logic                          valid;
  logic                          ready;
  logic [ctms_pkg::OP_W-1:0]     opcode;
  logic [ctms_pkg::IDX_W-1:0]    entry_index;
  logic [ctms_pkg::CHAN_W-1:0]   channel_number;
  logic [ctms_pkg::FLAGS_W-1:0]  entry_flags;
  logic [ctms_pkg::MODE_W-1:0]   wireless_mode;

  modport source (output valid, opcode, entry_index, channel_number, entry_flags,
                  wireless_mode, input ready);
  modport sink (input valid, opcode, entry_index, channel_number, entry_flags,
                wireless_mode, output ready);
endinterface

>>> hw/rtl/ctms_out_if.sv
`timescale 1ns / 1ps
interface ctms_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [ctms_pkg::IDX_W-1:0]   match_index;
  logic [ctms_pkg::CHAN_W-1:0]  match_channel;

  modport source (output valid, found, match_index, match_channel, input ready);
  modport sink (input valid, found, match_index, match_channel, output ready);
endinterface

>>> hw/rtl/ctms_ram.sv
`timescale 1ns / 1ps
module ctms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ctms_seq.sv
`timescale 1ns / 1ps
module ctms_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ctms_pkg::OP_W-1:0]     in_opcode,
  input  logic [ctms_pkg::IDX_W-1:0]    in_index,
  input  logic [ctms_pkg::CHAN_W-1:0]   in_chan,
  input  logic [ctms_pkg::FLAGS_W-1:0]  in_flags,
  input  logic [ctms_pkg::MODE_W-1:0]   in_mode,
  input  logic                          slot_free,
  output logic                          ram_we,
  output logic [ctms_pkg::TBL_AW-1:0]   ram_waddr,
  output logic [ctms_pkg::ENTRY_W-1:0]  ram_wdata,
  output logic                          ram_re,
  output logic [ctms_pkg::TBL_AW-1:0]   ram_raddr,
  output ctms_pkg::scan_ctl_t           ctl
);

  localparam int AW = ctms_pkg::TBL_AW;
  localparam int WW = AW + ctms_pkg::IDX_W;

  ctms_pkg::st_t st_r, st_nxt;
  ctms_pkg::op_t in_op;
  ctms_pkg::op_t op_r;
  logic [ctms_pkg::IDX_W-1:0]  idx_r;
  logic [ctms_pkg::CHAN_W-1:0] chan_r;
  logic [ctms_pkg::MODE_W-1:0] mode_r;
  logic [AW-1:0]               addr_r;
  logic                        rd_vld_r;
  logic [AW-1:0]               rd_slot_r;
  logic                        ent_vld_r;
  logic [ctms_pkg::TABLE_DEPTH-1:0] vld_r;
  logic                        accept;
  logic                        last;
  logic [WW-1:0]               wide_idx;
  logic                        in_range;
  logic                        fin;

  assign in_op    = ctms_pkg::op_t'(in_opcode);
  assign accept   = in_valid && in_ready;
  assign last     = (addr_r == AW'(ctms_pkg::TABLE_DEPTH - 1));
  assign wide_idx = {{AW{1'b0}}, in_index};
  assign in_range = (wide_idx < WW'(ctms_pkg::TABLE_DEPTH));

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ctms_pkg::ST_IDLE: begin
        if (in_valid) begin
          st_nxt = (in_op == ctms_pkg::OP_WRITE) ? ctms_pkg::ST_FINISH : ctms_pkg::ST_SCAN;
        end
      end
      ctms_pkg::ST_SCAN: begin
        if (last) begin
          st_nxt = ctms_pkg::ST_DRAIN;
        end
      end
      ctms_pkg::ST_DRAIN:  st_nxt = ctms_pkg::ST_FINISH;
      ctms_pkg::ST_FINISH: begin
        if (slot_free) begin
          st_nxt = ctms_pkg::ST_IDLE;
        end
      end
      default: st_nxt = ctms_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    ram_re   = 1'b0;
    fin      = 1'b0;
    case (st_r)
      ctms_pkg::ST_IDLE:   in_ready = 1'b1;
      ctms_pkg::ST_SCAN:   ram_re = 1'b1;
      ctms_pkg::ST_DRAIN:  ram_re = 1'b0;
      ctms_pkg::ST_FINISH: fin = 1'b1;
      default:             in_ready = 1'b0;
    endcase
  end

  // Write straight from the accepted beat; reads walk the table
  assign ram_we    = accept && (in_op == ctms_pkg::OP_WRITE) && in_range;
  assign ram_waddr = wide_idx[AW-1:0];
  assign ram_wdata = {in_flags, in_chan};
  assign ram_raddr = addr_r;

  assign ctl.clear     = accept;
  assign ctl.dvld      = rd_vld_r;
  assign ctl.ent_vld   = ent_vld_r;
  assign ctl.slot      = rd_slot_r;
  assign ctl.fin       = fin;
  assign ctl.op        = op_r;
  assign ctl.item_idx  = idx_r;
  assign ctl.item_chan = chan_r;
  assign ctl.item_mode = mode_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ctms_pkg::ST_IDLE;
      rd_vld_r <= 1'b0;
      vld_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      rd_vld_r <= ram_re;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Hold the item, advance the scan address, track the slot in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      idx_r  <= in_index;
      chan_r <= in_chan;
      mode_r <= in_mode;
      addr_r <= '0;
    end else if (ram_re) begin
      addr_r <= addr_r + AW'(1);
    end
    rd_slot_r <= addr_r;
    ent_vld_r <= vld_r[addr_r];
  end

endmodule

>>> hw/rtl/ctms_best.sv
`timescale 1ns / 1ps
module ctms_best (
  input  logic                          clk,
  input  ctms_pkg::scan_ctl_t           ctl,
  input  logic [ctms_pkg::ENTRY_W-1:0]  rdata,
  output logic                          res_found,
  output logic [ctms_pkg::IDX_W-1:0]    res_index,
  output logic [ctms_pkg::CHAN_W-1:0]   res_chan
);

  localparam int AW = ctms_pkg::TBL_AW;
  localparam int WW = AW + ctms_pkg::IDX_W;

  logic                        hit_r;
  logic [AW-1:0]               bidx_r;
  logic [ctms_pkg::CHAN_W-1:0] bchan_r;
  logic [ctms_pkg::CHAN_W-1:0] e_chan;
  logic [ctms_pkg::FLAGS_W-1:0] e_caps;
  logic                        elig;
  logic                        take;
  logic [WW-1:0]               wide_bidx;

  assign e_chan = rdata[ctms_pkg::CHAN_W-1:0];
  assign e_caps = rdata[ctms_pkg::ENTRY_W-1:ctms_pkg::CHAN_W];
  assign elig   = ctl.dvld && ctl.ent_vld &&
                  ctms_pkg::mode_accepts(e_chan, e_caps, ctl.item_mode);

  // Pick per query kind; first slot wins on ties
  always_comb begin
    case (ctl.op)
      ctms_pkg::OP_FIND: take = !hit_r && (e_chan == ctl.item_chan);
      ctms_pkg::OP_LOW:  take = !hit_r || (e_chan < bchan_r);
      ctms_pkg::OP_HIGH: take = !hit_r || (e_chan > bchan_r);
      default:           take = 1'b0;
    endcase
  end

  // Hold the best entry seen so far
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      hit_r <= 1'b0;
    end else if (elig && take) begin
      hit_r   <= 1'b1;
      bidx_r  <= ctl.slot;
      bchan_r <= e_chan;
    end
  end

  assign wide_bidx = {{ctms_pkg::IDX_W{1'b0}}, bidx_r};

  // Form the result beat
  always_comb begin
    if (ctl.op == ctms_pkg::OP_WRITE) begin
      res_found = 1'b0;
      res_index = ctl.item_idx;
      res_chan  = ctl.item_chan;
    end else if (hit_r) begin
      res_found = 1'b1;
      res_index = wide_bidx[ctms_pkg::IDX_W-1:0];
      res_chan  = bchan_r;
    end else begin
      res_found = 1'b0;
      res_index = '0;
      res_chan  = ctms_pkg::EMPTY_CHANNEL;
    end
  end

endmodule

>>> hw/rtl/channel_table_mode_search.sv
`timescale 1ns / 1ps
// Channel table with mode-filtered search.
// in_ch carries one beat per item: a write of one table slot (opcode 0) or a
// query (find channel, find lowest, find highest) filtered by wireless mode.
// out_ch returns exactly one beat per item: found, match_index, match_channel.
// Both channels use valid/ready; a beat moves when both are high.
// Items are handled one at a time. A write goes straight to the finish state,
// which loads its result into the output register once that register is free.
// A query reads the table memory one slot per cycle through its single read
// port, then passes through a drain state to the finish state. The next item
// can be accepted in the cycle after the result is loaded.
// in_ch.ready is high only while no item is in progress.
// The result sits in an output register; when the receiver stalls, the block
// holds it there. A new item can be accepted while that beat waits, but its
// own result, and with it the input, is held back until the beat is taken.
// Reset (rst_n low, synchronous) clears the per-slot valid bits so every slot
// reads as empty, and returns the sequencer to idle with no result pending.
module channel_table_mode_search (
  input logic      clk,
  input logic      rst_n,
  ctms_in_if.sink  in_ch,
  ctms_out_if.source out_ch
);

  logic                          slot_free;
  logic                          ram_we;
  logic [ctms_pkg::TBL_AW-1:0]   ram_waddr;
  logic [ctms_pkg::ENTRY_W-1:0]  ram_wdata;
  logic                          ram_re;
  logic [ctms_pkg::TBL_AW-1:0]   ram_raddr;
  logic [ctms_pkg::ENTRY_W-1:0]  ram_rdata;
  ctms_pkg::scan_ctl_t           ctl;
  logic                          res_found;
  logic [ctms_pkg::IDX_W-1:0]    res_index;
  logic [ctms_pkg::CHAN_W-1:0]   res_chan;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          out_found_r;
  logic [ctms_pkg::IDX_W-1:0]    out_index_r;
  logic [ctms_pkg::CHAN_W-1:0]   out_chan_r;
  logic                          load;

  ctms_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_opcode (in_ch.opcode),
    .in_index  (in_ch.entry_index),
    .in_chan   (in_ch.channel_number),
    .in_flags  (in_ch.entry_flags),
    .in_mode   (in_ch.wireless_mode),
    .slot_free (slot_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ctl       (ctl)
  );

  ctms_ram #(
    .WIDTH (ctms_pkg::ENTRY_W),
    .DEPTH (ctms_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ctms_best u_best (
    .clk       (clk),
    .ctl       (ctl),
    .rdata     (ram_rdata),
    .res_found (res_found),
    .res_index (res_index),
    .res_chan  (res_chan)
  );

  // Output register: load a finished result when the slot is free
  assign slot_free = !out_valid_r || out_ch.ready;
  assign load      = ctl.fin && slot_free;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_found_r <= res_found;
      out_index_r <= res_index;
      out_chan_r  <= res_chan;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.match_index   = out_index_r;
  assign out_ch.match_channel = out_chan_r;

endmodule

>>> tb/channel_table_mode_search_tb.sv
`timescale 1ns / 1ps
module channel_table_mode_search_tb;
  import ctms_pkg::*;

  // Capability flag masks
  localparam logic [FLAGS_W-1:0] CAP_NONE  = '0;
  localparam logic [FLAGS_W-1:0] CAP_24G   = FLAGS_W'(1 << F_24G);
  localparam logic [FLAGS_W-1:0] CAP_5G    = FLAGS_W'(1 << F_5G);
  localparam logic [FLAGS_W-1:0] CAP_HT20  = FLAGS_W'(1 << F_HT20);
  localparam logic [FLAGS_W-1:0] CAP_HT40P = FLAGS_W'(1 << F_HT40P);
  localparam logic [FLAGS_W-1:0] CAP_HT40M = FLAGS_W'(1 << F_HT40M);
  localparam logic [FLAGS_W-1:0] CAP_ALL   = '1;

  // Mode codes outside the defined set
  localparam logic [MODE_W-1:0] MODE_NONE_LO = 4'd12;
  localparam logic [MODE_W-1:0] MODE_NONE_HI = 4'd15;

  localparam logic [CHAN_W-1:0] TOP_CHANNEL = CHAN_W'(EMPTY_CHANNEL - 1);
  localparam int RANDOM_ITEMS = 650;
  localparam int MAX_WAIT     = 14;
  localparam int QUIET_SPAN   = 40;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [CHAN_W-1:0] chan;
  } scan_result_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   index;
    logic [CHAN_W-1:0]  chan;
    logic [FLAGS_W-1:0] flags;
    logic [MODE_W-1:0]  mode;
  } table_item_t;

  typedef struct packed {
    table_item_t  item;
    logic         typed;
    scan_result_t want;
  } directed_row_t;

  localparam scan_result_t MISS = '{1'b0, '0, EMPTY_CHANNEL};

  // Directed rows: empty table, extremes, empty marker, ties, every mode
  localparam int N_DIRECTED = 26;
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{OP_FIND,  6'd0,  16'd1,         CAP_NONE, MODE_G},        1'b1, MISS},
    '{'{OP_LOW,   6'd0,  16'd0,         CAP_NONE, MODE_A},        1'b1, MISS},
    '{'{OP_HIGH,  6'd0,  16'd0,         CAP_NONE, MODE_AC80},     1'b1, MISS},
    '{'{OP_WRITE, 6'd0,  16'd0,         CAP_ALL,  MODE_G},        1'b1,
      '{1'b0, 6'd0, 16'd0}},
    '{'{OP_WRITE, 6'd63, TOP_CHANNEL,   CAP_ALL,  MODE_G},        1'b1,
      '{1'b0, 6'd63, TOP_CHANNEL}},
    '{'{OP_WRITE, 6'd10, EMPTY_CHANNEL, CAP_ALL,  MODE_G},        1'b1,
      '{1'b0, 6'd10, EMPTY_CHANNEL}},
    '{'{OP_FIND,  6'd0,  16'd0,         CAP_NONE, MODE_G},        1'b1,
      '{1'b1, 6'd0, 16'd0}},
    '{'{OP_FIND,  6'd0,  EMPTY_CHANNEL, CAP_NONE, MODE_G},        1'b1, MISS},
    '{'{OP_LOW,   6'd0,  16'd0,         CAP_NONE, MODE_B},        1'b1,
      '{1'b1, 6'd0, 16'd0}},
    '{'{OP_HIGH,  6'd0,  16'd0,         CAP_NONE, MODE_A},        1'b1,
      '{1'b1, 6'd63, TOP_CHANNEL}},
    '{'{OP_HIGH,  6'd0,  16'd0,         CAP_ALL,  MODE_NONE_LO},  1'b1, MISS},
    '{'{OP_FIND,  6'd0,  16'd0,         CAP_ALL,  MODE_NONE_HI},  1'b1, MISS},
    '{'{OP_WRITE, 6'd20, TOP_CHANNEL,   CAP_5G | CAP_HT40P, MODE_G}, 1'b1,
      '{1'b0, 6'd20, TOP_CHANNEL}},
    '{'{OP_HIGH,  6'd0,  16'd0,         CAP_NONE, MODE_NA_HT40},  1'b0, '0},
    '{'{OP_HIGH,  6'd0,  16'd0,         CAP_NONE, MODE_NA_HT40M}, 1'b0, '0},
    '{'{OP_WRITE, 6'd5,  16'd36,        CAP_5G | CAP_HT40M, MODE_G}, 1'b1,
      '{1'b0, 6'd5, 16'd36}},
    '{'{OP_FIND,  6'd0,  16'd36,        CAP_NONE, MODE_NA_HT40M}, 1'b0, '0},
    '{'{OP_FIND,  6'd0,  16'd36,        CAP_NONE, MODE_NA_HT40P}, 1'b0, '0},
    '{'{OP_WRITE, 6'd7,  16'd0,         CAP_24G | CAP_HT20, MODE_G}, 1'b1,
      '{1'b0, 6'd7, 16'd0}},
    '{'{OP_LOW,   6'd0,  16'd0,         CAP_NONE, MODE_NG_HT20},  1'b0, '0},
    '{'{OP_WRITE, 6'd0,  16'd1,         CAP_NONE, MODE_G},        1'b1,
      '{1'b0, 6'd0, 16'd1}},
    '{'{OP_LOW,   6'd0,  16'd0,         CAP_NONE, MODE_NG_HT20},  1'b0, '0},
    '{'{OP_LOW,   6'd0,  16'd0,         CAP_NONE, MODE_NG_HT40P}, 1'b0, '0},
    '{'{OP_HIGH,  6'd0,  16'd0,         CAP_NONE, MODE_NG_HT40},  1'b0, '0},
    '{'{OP_LOW,   6'd0,  16'd0,         CAP_NONE, MODE_NA_HT20},  1'b0, '0},
    '{'{OP_FIND,  6'd0,  16'd1,         CAP_NONE, MODE_NG_HT40M}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  ctms_in_if  in_ch ();
  ctms_out_if out_ch ();

  channel_table_mode_search DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the channel table
  logic [CHAN_W-1:0]  tbl_chan [TABLE_DEPTH];
  logic [FLAGS_W-1:0] tbl_caps [TABLE_DEPTH];

  scan_result_t pending_results [$];
  scan_result_t want_beat;
  scan_result_t got_beat;
  int n_writes   = 0;
  int n_queries  = 0;
  int n_found    = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  bit quiet_in   = 1'b0;
  bit quiet_out  = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Decide whether an entry takes part in a search under a mode
  function automatic logic slot_eligible(logic [CHAN_W-1:0] chan, logic [FLAGS_W-1:0] caps,
                                         logic [MODE_W-1:0] mode);
    logic band_ok;
    logic [FLAGS_W-1:0] ht_need;
    if (chan == EMPTY_CHANNEL) return 1'b0;
    case (mode)
      MODE_G, MODE_B, MODE_NG_HT20, MODE_NG_HT40P, MODE_NG_HT40M, MODE_NG_HT40:
        band_ok = caps[F_24G];
      MODE_A, MODE_NA_HT20, MODE_NA_HT40P, MODE_NA_HT40M, MODE_NA_HT40, MODE_AC80:
        band_ok = caps[F_5G];
      default: return 1'b0;
    endcase
    case (mode)
      MODE_NG_HT20, MODE_NA_HT20:               ht_need = CAP_HT20;
      MODE_NG_HT40P, MODE_NA_HT40P:             ht_need = CAP_HT40P;
      MODE_NG_HT40M, MODE_NA_HT40M:             ht_need = CAP_HT40M;
      MODE_NG_HT40, MODE_NA_HT40, MODE_AC80:    ht_need = CAP_HT40P | CAP_HT40M;
      default:                                  ht_need = CAP_NONE;
    endcase
    return band_ok && (ht_need == CAP_NONE || (caps & ht_need) != CAP_NONE);
  endfunction

  // Apply one item to the shadow table and work out its result
  function automatic scan_result_t apply_channel_item(table_item_t it);
    scan_result_t r;
    logic take;
    r = MISS;
    if (it.op == OP_WRITE) begin
      if (it.index < TABLE_DEPTH) begin
        tbl_chan[it.index] = it.chan;
        tbl_caps[it.index] = it.flags;
      end
      r.index = it.index;
      r.chan  = it.chan;
      return r;
    end
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      if (slot_eligible(tbl_chan[s], tbl_caps[s], it.mode)) begin
        case (it.op)
          OP_FIND: take = !r.found && tbl_chan[s] == it.chan;
          OP_LOW:  take = !r.found || tbl_chan[s] < r.chan;
          default: take = !r.found || tbl_chan[s] > r.chan;
        endcase
        if (take) begin
          r.found = 1'b1;
          r.index = s[IDX_W-1:0];
          r.chan  = tbl_chan[s];
        end
      end
    end
    return r;
  endfunction

  // Mostly a small pool of channels so that ties and hits are common
  function automatic logic [CHAN_W-1:0] pick_channel();
    logic [CHAN_W-1:0] ch;
    case ($urandom_range(0, 9))
      0: ch = CHAN_W'($urandom_range(0, 65535));
      1: begin
        case ($urandom_range(0, 3))
          0:       ch = '0;
          1:       ch = EMPTY_CHANNEL;
          2:       ch = TOP_CHANNEL;
          default: ch = 16'd1;
        endcase
      end
      default: ch = CHAN_W'($urandom_range(1, 24));
    endcase
    return ch;
  endfunction

  function automatic table_item_t make_random_item();
    table_item_t it;
    int pick;
    pick     = $urandom_range(0, 9);
    it.op    = (pick < 4) ? OP_WRITE : (pick < 7) ? OP_FIND : (pick == 7) ? OP_LOW :
               (pick == 8) ? OP_HIGH : op_t'($urandom_range(0, 3));
    it.index = IDX_W'($urandom_range(0, 63));
    it.flags = FLAGS_W'($urandom_range(0, 31));
    it.mode  = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(12, 15))
                                           : MODE_W'($urandom_range(0, 11));
    // Searches mostly look for a channel that sits in the table
    if (it.op == OP_FIND && $urandom_range(0, 9) < 7)
      it.chan = tbl_chan[TBL_AW'($urandom_range(0, TABLE_DEPTH - 1))];
    else
      it.chan = pick_channel();
    return it;
  endfunction

  // Drive one beat after a random gap (none while quiet_in is set), then log its expected result
  task automatic drive_item(table_item_t it, logic typed, scan_result_t want);
    int gap;
    scan_result_t predicted;
    gap = quiet_in ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= it.op;
    in_ch.entry_index    <= it.index;
    in_ch.channel_number <= it.chan;
    in_ch.entry_flags    <= it.flags;
    in_ch.wireless_mode  <= it.mode;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_channel_item(it);
    pending_results.push_back(typed ? want : predicted);
    if (it.op == OP_WRITE) begin
      n_writes++;
    end else begin
      n_queries++;
      if (predicted.found) n_found++;
    end
  endtask

  // Stimulus: reset, directed rows, then random items
  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_WRITE;
    in_ch.entry_index    = '0;
    in_ch.channel_number = '0;
    in_ch.entry_flags    = '0;
    in_ch.wireless_mode  = MODE_G;
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      tbl_chan[s] = EMPTY_CHANNEL;
      tbl_caps[s] = CAP_ALL;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++)
      drive_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % QUIET_SPAN == 0) quiet_in = ($urandom_range(0, 3) == 0);
      drive_item(make_random_item(), 1'b0, '0);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d writes and %0d queries (%0d expected hits) over all wireless modes.",
             n_writes, n_queries, n_found);
    $display("Checked %0d result beats, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0)
      $display("channel_table_mode_search test passed");
    else
      $display("channel_table_mode_search test failed");
    $finish;
  end

  // Result side: stall for a random number of cycles before each beat, none while quiet_out is set
  initial begin
    int stall;
    int beats;
    beats        = 0;
    out_ch.ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (beats % QUIET_SPAN == 0) quiet_out = ($urandom_range(0, 3) == 0);
      stall = quiet_out ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      beats++;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_beat = '{out_ch.found, out_ch.match_index, out_ch.match_channel};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, found %0b index %0d channel %0d",
                 $time, got_beat.found, got_beat.index, got_beat.chan);
        n_errors++;
      end else begin
        want_beat = pending_results.pop_front();
        n_checked++;
        if (got_beat.found !== want_beat.found) begin
          $display("%0t: found expected %0b, got %0b", $time, want_beat.found, got_beat.found);
          n_errors++;
        end
        if (got_beat.index !== want_beat.index) begin
          $display("%0t: match_index expected %0d, got %0d",
                   $time, want_beat.index, got_beat.index);
          n_errors++;
        end
        if (got_beat.chan !== want_beat.chan) begin
          $display("%0t: match_channel expected %0d, got %0d",
                   $time, want_beat.chan, got_beat.chan);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #1_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("channel_table_mode_search test failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ctms_pkg.sv
hw/rtl/ctms_in_if.sv
hw/rtl/ctms_out_if.sv
hw/rtl/ctms_ram.sv
hw/rtl/ctms_seq.sv
hw/rtl/ctms_best.sv
hw/rtl/channel_table_mode_search.sv
tb/channel_table_mode_search_tb.sv
